// ===== sv/vcdr_pkg.sv =====
// Shared constants for the voxel chamfer distance and ridge block.
`default_nettype none
package vcdr_pkg;

  // Widths fixed by the register map and the result fields
  localparam int CFG_W  = 6;
  localparam int CIDX_W = 2;
  localparam int ACT_W  = 2;
  localparam int DOUT_W = 16;

  // Register indexes
  localparam logic [CIDX_W-1:0] REG_SIZE_X = 2'd0;
  localparam logic [CIDX_W-1:0] REG_SIZE_Y = 2'd1;
  localparam logic [CIDX_W-1:0] REG_SIZE_Z = 2'd2;

  // Input actions
  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RUN   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

  // Result kinds
  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // Q8 step costs: face, edge, corner neighbor
  localparam int COST_FACE   = 256;
  localparam int COST_EDGE   = 362;
  localparam int COST_CORNER = 443;

endpackage
`default_nettype wire

// ===== sv/voxel_chamfer_distance_ridge.sv =====
// Top level: voxel grid store with chamfer distance transform and ridge marking.
//
//  channel | signals                              | dir | transfer when
//  --------+--------------------------------------+-----+------------------------
//  cfg     | cfg_valid_i cfg_index_i cfg_data_i   | in  | cfg_valid_i & cfg_ready_o
//  in      | in_valid_i action pos_x/y/z occupied | in  | in_valid_i & !in_stall_o
//  out     | out_valid_o kind distance ridge ...  | out | out_valid_o & !out_stall_i
//
// Write: stored when accepted. Read: the registered RAM read, then the output register.
// Run: per sweep, (ext_x*ext_y*ext_z) voxels; init reads each voxel, drains and writes
//   it back; relax and ridge sweeps do a self read, a read per neighbor slot on the single
//   read port, drain, write back. Relax sweeps repeat until one changes nothing.
// After reset a pass clears all MAX_DIM^3 addresses; in_stall_o is high meanwhile.
// Config writes are always taken. A result waiting on out_stall_i holds the FSM only
//   when the next result is ready to load.
`default_nettype none
module voxel_chamfer_distance_ridge
  import vcdr_pkg::*;
#(
  parameter int MAX_DIM   = 32,
  parameter int DIST_BITS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output      logic                         cfg_ready_o,
  input  wire logic [CIDX_W-1:0]            cfg_index_i,
  input  wire logic [CFG_W-1:0]             cfg_data_i,
  input  wire logic                         in_valid_i,
  output      logic                         in_stall_o,
  input  wire logic [ACT_W-1:0]             action_i,
  input  wire logic [$clog2(MAX_DIM)-1:0]   pos_x_i,
  input  wire logic [$clog2(MAX_DIM)-1:0]   pos_y_i,
  input  wire logic [$clog2(MAX_DIM)-1:0]   pos_z_i,
  input  wire logic                         occupied_i,
  output      logic                         out_valid_o,
  input  wire logic                         out_stall_i,
  output      logic                         kind_o,
  output      logic [DOUT_W-1:0]            distance_o,
  output      logic                         on_ridge_o,
  output      logic                         is_obstacle_o,
  output      logic                         out_of_range_o
);

  localparam int CW    = $clog2(MAX_DIM);
  localparam int EW    = $clog2(MAX_DIM + 1);
  localparam int CMPW  = EW + 2;
  localparam int DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = DIST_BITS;
  localparam int WW    = (DW > DOUT_W) ? DW : DOUT_W;
  localparam logic [DW-1:0] DMAX = {DW{1'b1}};

  // FSM codes
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_SELF  = 3'd3;
  localparam logic [2:0] S_NB    = 3'd4;
  localparam logic [2:0] S_LAST  = 3'd5;
  localparam logic [2:0] S_WB    = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  localparam logic [1:0] PH_INIT  = 2'd0;
  localparam logic [1:0] PH_RELAX = 2'd1;
  localparam logic [1:0] PH_RIDGE = 2'd2;

  function automatic logic [EW-1:0] ext_of(input logic [CFG_W-1:0] s);
    if (int'(s) > MAX_DIM) begin
      return EW'(MAX_DIM);
    end
    return EW'(s);
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                            input logic [CW-1:0] z);
    return AW'((AW'(x) * AW'(MAX_DIM) + AW'(y)) * AW'(MAX_DIM) + AW'(z));
  endfunction

  function automatic logic [DW-1:0] sat_add(input logic [DW-1:0] a, input logic [DW-1:0] b);
    logic [DW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DW] ? DMAX : s[DW-1:0];
  endfunction

  // Registers
  logic [2:0]        state_q, state_d;
  logic [1:0]        phase_q, phase_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic [CFG_W-1:0]  size_x_q, size_y_q, size_z_q;
  logic [CW-1:0]     cx_q, cx_d, cy_q, cy_d, cz_q, cz_d;
  logic [1:0]        dx_q, dx_d, dy_q, dy_d, dz_q, dz_d;
  logic              changed_q, changed_d;
  logic              rd_oor_q, rd_oor_d;
  logic              p_self_q, p_nb_q;
  logic [DW-1:0]     p_cost_q;
  logic              cur_occ_q, cur_occ_d, cur_ridge_q, cur_ridge_d;
  logic [DW-1:0]     cur_dist_q, cur_dist_d, best_q, best_d;
  logic              racc_q, racc_d;
  logic              out_valid_q, out_valid_d;
  logic              out_kind_q, out_kind_d, out_ridge_q, out_ridge_d;
  logic              out_obst_q, out_obst_d, out_oor_q, out_oor_d;
  logic [DOUT_W-1:0] out_dist_q, out_dist_d;

  // RAM ports
  logic          occ_we, dr_we, ram_re, occ_wdata, occ_rdata;
  logic [AW-1:0] occ_waddr, dr_waddr, ram_raddr;
  logic [DW:0]   dr_wdata, dr_rdata;

  vcdr_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_occ_ram (
    .clk_i  (clk_i),
    .we_i   (occ_we),
    .waddr_i(occ_waddr),
    .wdata_i(occ_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(occ_rdata)
  );

  vcdr_ram #(.WIDTH(DW + 1), .DEPTH(DEPTH)) u_dr_ram (
    .clk_i  (clk_i),
    .we_i   (dr_we),
    .waddr_i(dr_waddr),
    .wdata_i(dr_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(dr_rdata)
  );

  // Extents and bounds
  logic [EW-1:0] ext_x, ext_y, ext_z;
  logic          pos_ok, ext_empty, in_acc, can_load;

  assign ext_x     = ext_of(size_x_q);
  assign ext_y     = ext_of(size_y_q);
  assign ext_z     = ext_of(size_z_q);
  assign ext_empty = (ext_x == '0) || (ext_y == '0) || (ext_z == '0);
  assign pos_ok    = (CMPW'(pos_x_i) < CMPW'(ext_x)) && (CMPW'(pos_y_i) < CMPW'(ext_y)) &&
                     (CMPW'(pos_z_i) < CMPW'(ext_z));
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign can_load   = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  // Neighbor coordinates and step cost
  logic [CMPW-1:0] tx, ty, tz, mx, my, mz;
  logic            nb_ok, nb_center, nb_last;
  logic [1:0]      nb_cnt;
  logic [DW-1:0]   nb_cost;

  always_comb begin
    tx = CMPW'(cx_q) + CMPW'(dx_q);
    ty = CMPW'(cy_q) + CMPW'(dy_q);
    tz = CMPW'(cz_q) + CMPW'(dz_q);
    mx = tx - CMPW'(1);
    my = ty - CMPW'(1);
    mz = tz - CMPW'(1);
    nb_center = (dx_q == 2'd1) && (dy_q == 2'd1) && (dz_q == 2'd1);
    nb_ok = (tx != '0) && (ty != '0) && (tz != '0) && (mx < CMPW'(ext_x)) &&
            (my < CMPW'(ext_y)) && (mz < CMPW'(ext_z)) && !nb_center;
    nb_last = (dx_q == 2'd2) && (dy_q == 2'd2) && (dz_q == 2'd2);
    nb_cnt = 2'((dx_q != 2'd1)) + 2'((dy_q != 2'd1)) + 2'((dz_q != 2'd1));
    case (nb_cnt)
      2'd3:    nb_cost = DW'(COST_CORNER);
      2'd2:    nb_cost = DW'(COST_EDGE);
      default: nb_cost = DW'(COST_FACE);
    endcase
  end

  // Accumulate self and neighbor data in the cycle after each read is issued
  logic [DW-1:0] n_base, n_cand, n_need;
  always_comb begin
    cur_occ_d   = cur_occ_q;
    cur_ridge_d = cur_ridge_q;
    cur_dist_d  = cur_dist_q;
    best_d      = best_q;
    racc_d      = racc_q;
    n_base = occ_rdata ? '0 : dr_rdata[DW-1:0];
    n_cand = sat_add(n_base, p_cost_q);
    n_need = sat_add(cur_dist_q, p_cost_q);
    if (p_self_q) begin
      cur_occ_d   = occ_rdata;
      cur_ridge_d = dr_rdata[DW];
      cur_dist_d  = dr_rdata[DW-1:0];
      best_d      = dr_rdata[DW-1:0];
      racc_d      = 1'b1;
    end else if (p_nb_q) begin
      if (n_cand < best_q) begin
        best_d = n_cand;
      end
      if (!occ_rdata && (dr_rdata[DW-1:0] >= n_need)) begin
        racc_d = 1'b0;
      end
    end
  end

  // Cursor end-of-axis flags
  logic last_x, last_y, last_z, relax_wr;
  assign last_x = (CMPW'(cx_q) + CMPW'(1)) == CMPW'(ext_x);
  assign last_y = (CMPW'(cy_q) + CMPW'(1)) == CMPW'(ext_y);
  assign last_z = (CMPW'(cz_q) + CMPW'(1)) == CMPW'(ext_z);
  assign relax_wr = !cur_occ_q && (best_q < cur_dist_q);

  // Read data widened for clamping to the output width
  logic [WW-1:0] rd_wide;
  assign rd_wide = WW'(dr_rdata[DW-1:0]);

  // Main sequencer
  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    clr_d     = clr_q;
    cx_d = cx_q; cy_d = cy_q; cz_d = cz_q;
    dx_d = dx_q; dy_d = dy_q; dz_d = dz_q;
    changed_d = changed_q;
    rd_oor_d  = rd_oor_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_kind_d  = out_kind_q;
    out_dist_d  = out_dist_q;
    out_ridge_d = out_ridge_q;
    out_obst_d  = out_obst_q;
    out_oor_d   = out_oor_q;
    occ_we = 1'b0; occ_waddr = addr_of(pos_x_i, pos_y_i, pos_z_i); occ_wdata = occupied_i;
    dr_we  = 1'b0; dr_waddr = addr_of(cx_q, cy_q, cz_q); dr_wdata = {cur_ridge_q, cur_dist_q};
    ram_re = 1'b0; ram_raddr = addr_of(pos_x_i, pos_y_i, pos_z_i);

    case (state_q)
      S_CLEAR: begin
        occ_we = 1'b1; occ_waddr = clr_q; occ_wdata = 1'b0;
        dr_we  = 1'b1; dr_waddr = clr_q; dr_wdata = {1'b0, DMAX};
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          case (action_i)
            ACT_WRITE: occ_we = pos_ok;
            ACT_READ: begin
              ram_re   = 1'b1;
              rd_oor_d = !pos_ok;
              state_d  = S_RD;
            end
            ACT_RUN: begin
              cx_d = '0; cy_d = '0; cz_d = '0;
              phase_d = PH_INIT;
              state_d = ext_empty ? S_DONE : S_SELF;
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          out_kind_d  = KIND_READ;
          out_oor_d   = rd_oor_q;
          out_dist_d  = '0; out_ridge_d = 1'b0; out_obst_d = 1'b0;
          if (!rd_oor_q) begin
            out_dist_d  = (rd_wide > WW'({DOUT_W{1'b1}})) ? {DOUT_W{1'b1}} : rd_wide[DOUT_W-1:0];
            out_ridge_d = dr_rdata[DW];
            out_obst_d  = occ_rdata;
          end
          state_d = S_IDLE;
        end
      end
      S_SELF: begin
        ram_re = 1'b1; ram_raddr = addr_of(cx_q, cy_q, cz_q);
        dx_d = '0; dy_d = '0; dz_d = '0;
        state_d = (phase_q == PH_INIT) ? S_LAST : S_NB;
      end
      S_NB: begin
        ram_re = 1'b1; ram_raddr = addr_of(mx[CW-1:0], my[CW-1:0], mz[CW-1:0]);
        if (dz_q != 2'd2) begin
          dz_d = dz_q + 2'd1;
        end else begin
          dz_d = '0;
          if (dy_q != 2'd2) begin
            dy_d = dy_q + 2'd1;
          end else begin
            dy_d = '0;
            dx_d = dx_q + 2'd1;
          end
        end
        if (nb_last) begin
          state_d = S_LAST;
        end
      end
      S_LAST: state_d = S_WB;
      S_WB: begin
        // Write back by phase
        case (phase_q)
          PH_INIT: begin
            dr_we = 1'b1; dr_wdata = {cur_ridge_q, cur_occ_q ? {DW{1'b0}} : DMAX};
          end
          PH_RELAX: begin
            dr_we = relax_wr; dr_wdata = {cur_ridge_q, best_q};
            if (relax_wr) changed_d = 1'b1;
          end
          default: begin
            dr_we = 1'b1; dr_wdata = {!cur_occ_q && racc_q, cur_dist_q};
          end
        endcase
        // Advance the cursor; at the end of a sweep pick the next phase, or finish after the ridge sweep
        state_d = S_SELF;
        if (!last_z) begin
          cz_d = cz_q + CW'(1);
        end else begin
          cz_d = '0;
          if (!last_y) begin
            cy_d = cy_q + CW'(1);
          end else begin
            cy_d = '0;
            if (!last_x) begin
              cx_d = cx_q + CW'(1);
            end else begin
              cx_d = '0;
              changed_d = 1'b0;
              case (phase_q)
                PH_INIT:  phase_d = PH_RELAX;
                PH_RELAX: phase_d = (changed_q || relax_wr) ? PH_RELAX : PH_RIDGE;
                default:  state_d = S_DONE;
              endcase
            end
          end
        end
      end
      S_DONE: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          out_kind_d  = KIND_DONE;
          out_dist_d  = '0; out_ridge_d = 1'b0; out_obst_d = 1'b0; out_oor_d = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      phase_q     <= PH_INIT;
      clr_q       <= '0;
      changed_q   <= 1'b0;
      p_self_q    <= 1'b0;
      p_nb_q      <= 1'b0;
      out_valid_q <= 1'b0;
      size_x_q    <= CFG_W'(32);
      size_y_q    <= CFG_W'(32);
      size_z_q    <= CFG_W'(32);
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      clr_q       <= clr_d;
      changed_q   <= changed_d;
      p_self_q    <= (state_q == S_SELF);
      p_nb_q      <= (state_q == S_NB) && nb_ok;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_SIZE_X: size_x_q <= cfg_data_i;
          REG_SIZE_Y: size_y_q <= cfg_data_i;
          REG_SIZE_Z: size_z_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    cx_q <= cx_d; cy_q <= cy_d; cz_q <= cz_d;
    dx_q <= dx_d; dy_q <= dy_d; dz_q <= dz_d;
    rd_oor_q    <= rd_oor_d;
    p_cost_q    <= nb_cost;
    cur_occ_q   <= cur_occ_d;
    cur_ridge_q <= cur_ridge_d;
    cur_dist_q  <= cur_dist_d;
    best_q      <= best_d;
    racc_q      <= racc_d;
    out_kind_q  <= out_kind_d;
    out_dist_q  <= out_dist_d;
    out_ridge_q <= out_ridge_d;
    out_obst_q  <= out_obst_d;
    out_oor_q   <= out_oor_d;
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_kind_q;
  assign distance_o     = out_dist_q;
  assign on_ridge_o     = out_ridge_q;
  assign is_obstacle_o  = out_obst_q;
  assign out_of_range_o = out_oor_q;

  // Checks
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_oor_q) |-> (out_dist_q == '0 && !out_ridge_q && !out_obst_q))
    else $error("out-of-range answer carries data");

  a_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_we && state_q == S_IDLE) |-> (in_acc && action_i == ACT_WRITE && pos_ok))
    else $error("occupancy write without a write transfer");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_RD || $past(state_q) == S_DONE))
    else $error("result loaded outside read or done");

endmodule
`default_nettype wire

// ===== sv/vcdr_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module vcdr_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== tb/sv/tb_voxel_chamfer_distance_ridge.sv =====
// Testbench for the voxel chamfer distance and ridge block: directed and random traffic.
`default_nettype none

typedef struct {
  logic        kind;
  logic [15:0] distance;
  logic        on_ridge;
  logic        is_obstacle;
  logic        out_of_range;
} voxel_answer_t;

// Grid model plus the queue of answers still owed by the block
class voxel_scoreboard;
  localparam int DIM = 32;
  localparam int VOXELS = DIM * DIM * DIM;
  localparam int DMAX = 65535;

  bit          occ_map[VOXELS];
  int unsigned dist_map[VOXELS];
  bit          ridge_map[VOXELS];
  int          ext[3];
  voxel_answer_t owed[$];
  int errors;
  int results;
  int runs;
  int items;

  function new();
    foreach (dist_map[i]) dist_map[i] = DMAX;
    foreach (ext[i]) ext[i] = DIM;
    errors = 0;
    results = 0;
    runs = 0;
    items = 0;
  endfunction

  function void set_size(int idx, int value);
    ext[idx] = (value > DIM) ? DIM : value;
  endfunction

  function int pending();
    return owed.size();
  endfunction

  function bit in_extent(int x, int y, int z);
    return x >= 0 && x < ext[0] && y >= 0 && y < ext[1] && z >= 0 && z < ext[2];
  endfunction

  function int addr(int x, int y, int z);
    return (x * DIM + y) * DIM + z;
  endfunction

  function int unsigned sat_sum(int unsigned a, int unsigned b);
    return (a + b > DMAX) ? DMAX : a + b;
  endfunction

  function int unsigned step_cost(int dx, int dy, int dz);
    int n;
    n = (dx != 0) + (dy != 0) + (dz != 0);
    return (n == 3) ? vcdr_pkg::COST_CORNER : (n == 2) ? vcdr_pkg::COST_EDGE
         : vcdr_pkg::COST_FACE;
  endfunction

  // One relaxation of a free voxel against its in-range neighbors
  function bit relax_voxel(int x, int y, int z);
    int c, n;
    int unsigned best, base, cand;
    c = addr(x, y, z);
    best = dist_map[c];
    if (occ_map[c]) return 0;
    for (int dx = -1; dx <= 1; dx++)
      for (int dy = -1; dy <= 1; dy++)
        for (int dz = -1; dz <= 1; dz++) begin
          if ((dx == 0 && dy == 0 && dz == 0) || !in_extent(x+dx, y+dy, z+dz)) continue;
          n = addr(x+dx, y+dy, z+dz);
          base = occ_map[n] ? 0 : dist_map[n];
          cand = sat_sum(base, step_cost(dx, dy, dz));
          if (cand < best) best = cand;
        end
    if (best < dist_map[c]) begin
      dist_map[c] = best;
      return 1;
    end
    return 0;
  endfunction

  // Free voxel with no free neighbor reaching its distance plus the step
  function bit ridge_at(int x, int y, int z);
    int c, n;
    c = addr(x, y, z);
    if (occ_map[c]) return 0;
    for (int dx = -1; dx <= 1; dx++)
      for (int dy = -1; dy <= 1; dy++)
        for (int dz = -1; dz <= 1; dz++) begin
          if ((dx == 0 && dy == 0 && dz == 0) || !in_extent(x+dx, y+dy, z+dz)) continue;
          n = addr(x+dx, y+dy, z+dz);
          if (occ_map[n]) continue;
          if (dist_map[n] >= sat_sum(dist_map[c], step_cost(dx, dy, dz))) return 0;
        end
    return 1;
  endfunction

  function void transform();
    bit changed;
    for (int x = 0; x < ext[0]; x++)
      for (int y = 0; y < ext[1]; y++)
        for (int z = 0; z < ext[2]; z++)
          dist_map[addr(x, y, z)] = occ_map[addr(x, y, z)] ? 0 : DMAX;
    changed = 1;
    while (changed) begin
      changed = 0;
      for (int x = 0; x < ext[0]; x++)
        for (int y = 0; y < ext[1]; y++)
          for (int z = 0; z < ext[2]; z++)
            if (relax_voxel(x, y, z)) changed = 1;
      for (int x = ext[0] - 1; x >= 0; x--)
        for (int y = ext[1] - 1; y >= 0; y--)
          for (int z = ext[2] - 1; z >= 0; z--)
            if (relax_voxel(x, y, z)) changed = 1;
    end
    for (int x = 0; x < ext[0]; x++)
      for (int y = 0; y < ext[1]; y++)
        for (int z = 0; z < ext[2]; z++)
          ridge_map[addr(x, y, z)] = ridge_at(x, y, z);
  endfunction

  // Accepted input transfer: update the grid and queue any answer
  function void note_input(logic [1:0] act, int x, int y, int z, bit occupied);
    voxel_answer_t a;
    items++;
    a = '{kind: vcdr_pkg::KIND_READ, distance: 0, on_ridge: 0, is_obstacle: 0,
          out_of_range: 0};
    case (act)
      vcdr_pkg::ACT_WRITE: begin
        if (in_extent(x, y, z)) occ_map[addr(x, y, z)] = occupied;
      end
      vcdr_pkg::ACT_RUN: begin
        transform();
        runs++;
        a.kind = vcdr_pkg::KIND_DONE;
        owed = {owed, a};
      end
      vcdr_pkg::ACT_READ: begin
        if (in_extent(x, y, z)) begin
          a.distance = 16'(dist_map[addr(x, y, z)]);
          a.on_ridge = ridge_map[addr(x, y, z)];
          a.is_obstacle = occ_map[addr(x, y, z)];
        end else begin
          a.out_of_range = 1;
        end
        owed = {owed, a};
      end
      default: ;
    endcase
  endfunction

  // Accepted output transfer against the oldest owed answer
  function void check_result(voxel_answer_t got);
    voxel_answer_t exp;
    results++;
    if (owed.size() == 0) begin
      $display("%0t: unexpected result kind=%0d distance=%0d", $time, got.kind,
               got.distance);
      errors++;
      return;
    end
    exp = owed.pop_front();
    if (got.kind !== exp.kind) begin
      $display("%0t: kind expected %0d actual %0d", $time, exp.kind, got.kind);
      errors++;
    end
    if (got.distance !== exp.distance) begin
      $display("%0t: distance expected %0d actual %0d", $time, exp.distance, got.distance);
      errors++;
    end
    if (got.on_ridge !== exp.on_ridge) begin
      $display("%0t: on_ridge expected %0d actual %0d", $time, exp.on_ridge, got.on_ridge);
      errors++;
    end
    if (got.is_obstacle !== exp.is_obstacle) begin
      $display("%0t: is_obstacle expected %0d actual %0d", $time, exp.is_obstacle,
               got.is_obstacle);
      errors++;
    end
    if (got.out_of_range !== exp.out_of_range) begin
      $display("%0t: out_of_range expected %0d actual %0d", $time, exp.out_of_range,
               got.out_of_range);
      errors++;
    end
  endfunction
endclass

module tb_voxel_chamfer_distance_ridge
  import vcdr_pkg::*;
();

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 20000000;
  localparam int SETTLE_CYCLES = 20;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CIDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [ACT_W-1:0] action_i = '0;
  logic [4:0] pos_x_i = '0;
  logic [4:0] pos_y_i = '0;
  logic [4:0] pos_z_i = '0;
  logic occupied_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic kind_o;
  logic [DOUT_W-1:0] distance_o;
  logic on_ridge_o;
  logic is_obstacle_o;
  logic out_of_range_o;

  voxel_scoreboard sb = new();
  int burst_left = 0;
  int cycles = 0;
  int ext_x = 32, ext_y = 32, ext_z = 32;
  bit hold_req = 1'b0;

  voxel_chamfer_distance_ridge uut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .action_i, .pos_x_i, .pos_y_i, .pos_z_i, .occupied_i,
    .out_valid_o, .out_stall_i, .kind_o, .distance_o, .on_ridge_o, .is_obstacle_o,
    .out_of_range_o
  );

  always #10 clk_i = ~clk_i;

  // Cycle budget
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_voxel_chamfer_distance_ridge: done, errors");
      $finish;
    end
  end

  // Output monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result('{kind: kind_o, distance: distance_o, on_ridge: on_ridge_o,
                        is_obstacle: is_obstacle_o, out_of_range: out_of_range_o});
  end

  // Receiver stall: one long hold-off on request, else segments of varying density
  initial begin : stall_gen
    int seg_left, density;
    bit held;
    held = 0;
    seg_left = 0;
    density = 0;
    @(posedge rst_ni);
    forever begin
      if (!held && hold_req) begin
        held = 1;
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(1, 30);
          density = $urandom_range(0, 3);
        end
        out_stall_i <= (density != 0) && ($urandom_range(0, 3) < density);
        seg_left--;
        @(posedge clk_i);
      end
    end
  end

  // Three register transfers back to back
  task automatic set_grid(int sx, int sy, int sz);
    int v[3];
    v = '{sx, sy, sz};
    for (int i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= (i == 0) ? REG_SIZE_X : (i == 1) ? REG_SIZE_Y : REG_SIZE_Z;
      cfg_data_i <= CFG_W'(v[i]);
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.set_size(i, v[i]);
    end
    cfg_valid_i <= 1'b0;
    ext_x = (sx > 32) ? 32 : sx;
    ext_y = (sy > 32) ? 32 : sy;
    ext_z = (sz > 32) ? 32 : sz;
  endtask

  // One input transfer, sent in bursts with random gaps
  task automatic send(logic [ACT_W-1:0] act, int x, int y, int z, int occ);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    pos_x_i <= 5'(x);
    pos_y_i <= 5'(y);
    pos_z_i <= 5'(z);
    occupied_i <= (occ != 0);
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(act, x, y, z, occ != 0);
    burst_left--;
  endtask

  // Drain owed answers, then let a trailing write settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic int coord(int extent);
    return (extent == 0) ? $urandom_range(0, 31) : $urandom_range(0, extent - 1);
  endfunction

  initial begin : main
    int r, sx, sy, sz;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: corners, obstacles, ignored writes and actions, out-of-range reads
    set_grid(4, 3, 2);
    send(ACT_READ, 1, 1, 1, 0);
    send(ACT_WRITE, 0, 0, 0, 1);
    send(ACT_WRITE, 3, 2, 1, 1);
    send(ACT_WRITE, 1, 1, 1, 0);
    send(ACT_WRITE, 31, 31, 31, 1);
    send(ACT_UNUSED, 31, 31, 31, 1);
    send(ACT_RUN, 0, 0, 0, 0);
    send(ACT_READ, 0, 0, 0, 0);
    send(ACT_READ, 1, 1, 1, 0);
    send(ACT_READ, 3, 2, 1, 0);
    send(ACT_READ, 2, 1, 0, 0);
    send(ACT_READ, 4, 0, 0, 0);
    send(ACT_READ, 0, 3, 0, 0);
    send(ACT_READ, 0, 0, 2, 0);
    send(ACT_READ, 31, 31, 31, 0);
    wait_idle();
    // Single free voxel: unreachable and isolated
    set_grid(1, 1, 1);
    send(ACT_WRITE, 0, 0, 0, 0);
    send(ACT_RUN, 0, 0, 0, 0);
    send(ACT_READ, 0, 0, 0, 0);
    wait_idle();
    // Empty extent on one axis
    set_grid(0, 5, 5);
    send(ACT_WRITE, 0, 0, 0, 1);
    send(ACT_RUN, 0, 0, 0, 0);
    send(ACT_READ, 0, 0, 0, 0);
    wait_idle();
    // Long receiver hold-off while reads keep arriving, so the input stalls
    hold_req = 1'b1;
    for (int k = 0; k < 12; k++) send(ACT_READ, k, 0, 0, 0);
    wait_idle();

    // Random phases: edit the grid, run, read back, plus some noise
    for (int phase = 0; phase < 12; phase++) begin
      case (phase)
        0: begin sx = 32; sy = 1; sz = 1; end
        1: begin sx = 1; sy = 32; sz = 2; end
        2: begin sx = 2; sy = 2; sz = 32; end
        3: begin sx = 63; sy = 1; sz = 1; end
        default: begin
          sx = $urandom_range(1, 4); sy = $urandom_range(1, 4); sz = $urandom_range(1, 4);
        end
      endcase
      set_grid(sx, sy, sz);
      for (int k = 0; k < 42; k++) begin
        r = $urandom_range(0, 99);
        if (r < 45)
          send(ACT_WRITE, coord(ext_x), coord(ext_y), coord(ext_z), $urandom_range(0, 1));
        else if (r < 82)
          send(ACT_READ, coord(ext_x), coord(ext_y), coord(ext_z), $urandom_range(0, 1));
        else if (r < 88)
          send(ACT_RUN, $urandom_range(0, 31), $urandom_range(0, 31),
               $urandom_range(0, 31), $urandom_range(0, 1));
        else
          send(ACT_W'($urandom_range(0, 3)), $urandom_range(0, 31), $urandom_range(0, 31),
               $urandom_range(0, 31), $urandom_range(0, 1));
      end
      send(ACT_RUN, 0, 0, 0, 0);
      send(ACT_READ, coord(ext_x), coord(ext_y), coord(ext_z), 0);
      wait_idle();
    end

    $display("covered %0d input transfers, %0d results, %0d transform runs",
             sb.items, sb.results, sb.runs);
    $display("grid sizes from empty and single voxel up to full length on each axis");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_voxel_chamfer_distance_ridge: done, clean");
    end else begin
      $display("tb_voxel_chamfer_distance_ridge: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
sv/vcdr_pkg.sv
sv/vcdr_ram.sv
sv/voxel_chamfer_distance_ridge.sv
tb/sv/tb_voxel_chamfer_distance_ridge.sv
